// ----- hdl/huffman_bit_packer_unit_macros.svh -----
// Assertion macros used by the port checker of the Huffman bit packer.
`ifndef HUFFMAN_BIT_PACKER_UNIT_MACROS_SVH
`define HUFFMAN_BIT_PACKER_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HBP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("huffman bit packer port check failed");

// Consequent checked in the cycle after the antecedent.
`define HBP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("huffman bit packer port check failed");

`endif

// ----- hdl/hbp_pkg.sv -----
// Types and constants shared by the Huffman bit packer modules.
package hbp_pkg;

	localparam int BYTE_BITS     = 8;
	localparam int WORD_BITS     = 16;
	localparam int LEN_BITS      = 5;
	localparam int SYM_BITS      = 8;
	localparam int CMD_BITS      = 2;
	localparam int PEND_BITS     = 7;
	localparam int PCNT_BITS     = 3;
	localparam int PAD_BITS      = 4;
	localparam int ACC_BITS      = PEND_BITS + WORD_BITS;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_CNT_BITS = 3;

	typedef enum logic [CMD_BITS-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_ENCODE = 2'd1,
		CMD_FLUSH  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_BITS-1:0]  command;
		logic [SYM_BITS-1:0]  symbol;
		logic [WORD_BITS-1:0] code_word;
		logic [LEN_BITS-1:0]  code_length;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] out_byte;
		logic [PAD_BITS-1:0]  pad_bits;
		logic                 is_last;
	} out_word_t;

	// Control of the item held in the packing stage.
	typedef struct packed {
		logic                valid;
		logic [CMD_BITS-1:0] cmd;
		logic                sym_ok;
	} pack_ctl_t;

	// Up to two result words produced by one item.
	typedef struct packed {
		logic [1:0] n;
		out_word_t  w0;
		out_word_t  w1;
	} pack_res_t;

endpackage

// ----- hdl/hbp_code_table.sv -----
// Code table memory: clamps and writes load items, reads the entry of an encode item.
module hbp_code_table
	import hbp_pkg::*;
#(
	parameter int SYMBOL_COUNT = 256,
	parameter int MAX_CODE_LEN = 16,
	localparam int CAP    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS,
	localparam int LEN_W  = $clog2(CAP + 1),
	localparam int CODE_W = CAP,
	localparam int IDX_W  = $clog2(SYMBOL_COUNT)
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     idx,
	input  logic [WORD_BITS-1:0] code_word,
	input  logic [LEN_BITS-1:0]  code_length,
	output logic [CODE_W-1:0]    rd_code_q,
	output logic [LEN_W-1:0]     rd_len_q
);

	logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
	logic [LEN_BITS-1:0]     len_cl;
	logic [WORD_BITS-1:0]    mask;
	logic [WORD_BITS-1:0]    code_m;

	always_comb begin
		len_cl = (code_length > LEN_BITS'(CAP)) ? LEN_BITS'(CAP) : code_length;
		mask   = ~({WORD_BITS{1'b1}} << len_cl);
		code_m = code_word & mask;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= {len_cl[LEN_W-1:0], code_m[CODE_W-1:0]};
		end
		if (rd_en) begin
			{rd_len_q, rd_code_q} <= mem[idx];
		end
	end

endmodule

// ----- hdl/hbp_packer.sv -----
// Bit accumulator: merges one code into the pending bits and cuts out full bytes, or flushes them as a padded byte.
module hbp_packer
	import hbp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  pack_ctl_t            ctl,
	input  logic                 adv,
	input  logic [WORD_BITS-1:0] code,
	input  logic [LEN_BITS-1:0]  len,
	output pack_res_t            res
);

	logic [PEND_BITS-1:0]             pend_q;
	logic [PCNT_BITS-1:0]             pcnt_q;
	logic [PEND_BITS-1:0]             pend_d;
	logic [PCNT_BITS-1:0]             pcnt_d;
	logic [ACC_BITS-1:0]              acc;
	logic [LEN_BITS-1:0]              cnt;
	logic [LEN_BITS-1:0]              rem;
	logic [ACC_BITS-1:0]              t0;
	logic [ACC_BITS-1:0]              t1;
	logic [PEND_BITS+BYTE_BITS-1:0]   fl;
	logic                             upd;

	always_comb begin
		res    = '0;
		pend_d = pend_q;
		pcnt_d = pcnt_q;
		upd    = 1'b0;
		acc    = (ACC_BITS'(pend_q) << len) | ACC_BITS'(code);
		cnt    = LEN_BITS'(pcnt_q) + len;
		t0     = acc >> (cnt - LEN_BITS'(BYTE_BITS));
		t1     = acc >> (cnt - LEN_BITS'(2 * BYTE_BITS));
		fl     = {pend_q, {BYTE_BITS{1'b0}}} >> pcnt_q;
		rem    = cnt;
		if (ctl.valid) begin
			unique case (ctl.cmd)
				CMD_ENCODE: begin
					if (ctl.sym_ok && len != '0) begin
						upd = 1'b1;
						if (cnt >= LEN_BITS'(2 * BYTE_BITS)) begin
							res.n  = 2'd2;
							res.w0 = '{out_byte: t0[BYTE_BITS-1:0], pad_bits: '0,
								is_last: 1'b0};
							res.w1 = '{out_byte: t1[BYTE_BITS-1:0], pad_bits: '0,
								is_last: 1'b1};
							rem    = cnt - LEN_BITS'(2 * BYTE_BITS);
						end else if (cnt >= LEN_BITS'(BYTE_BITS)) begin
							res.n  = 2'd1;
							res.w0 = '{out_byte: t0[BYTE_BITS-1:0], pad_bits: '0,
								is_last: 1'b1};
							rem    = cnt - LEN_BITS'(BYTE_BITS);
						end
						pcnt_d = rem[PCNT_BITS-1:0];
						pend_d = acc[PEND_BITS-1:0] & ~({PEND_BITS{1'b1}} << pcnt_d);
					end
				end
				CMD_FLUSH: begin
					upd    = 1'b1;
					res.n  = 2'd1;
					res.w0 = '{out_byte: fl[BYTE_BITS-1:0],
						pad_bits: PAD_BITS'(BYTE_BITS) - PAD_BITS'(pcnt_q), is_last: 1'b1};
					pend_d = '0;
					pcnt_d = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			pcnt_q <= '0;
		end else if (adv && upd) begin
			pend_q <= pend_d;
			pcnt_q <= pcnt_d;
		end
	end

endmodule

// ----- hdl/hbp_out_fifo.sv -----
// Four-word result queue that takes up to two words a cycle and gives one while res_stall is low.
module hbp_out_fifo
	import hbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pack_res_t push,
	input  logic      res_stall,
	output logic      res_valid,
	output out_word_t res_data,
	output logic      room
);

	out_word_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_ptr_q;
	logic [FIFO_PTR_BITS-1:0] rd_ptr_q;
	logic [FIFO_CNT_BITS-1:0] count_q;
	logic                     pop;

	assign res_valid = (count_q != '0);
	assign res_data  = mem_q[rd_ptr_q];
	assign pop       = res_valid && !res_stall;
	// Room for a full two-word item, judged on the registered count.
	assign room      = (count_q <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.w0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= push.w1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_BITS'(push.n);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_BITS'(pop);
			count_q  <= count_q + FIFO_CNT_BITS'(push.n) - FIFO_CNT_BITS'(pop);
		end
	end

endmodule

// ----- hdl/huffman_bit_packer_unit.sv -----
// Huffman bit packer top level: code table, packing stage and result queue.
// One command word is taken per cycle unless cmd_stall holds it. A load writes the code table and
// gives no result; an encode gives zero, one or two byte words; a flush gives one word with the
// padding count; command three is ignored. The table is read in the cycle a word is taken, the
// packing stage merges the code into the pending bits in the next cycle, and the result words
// are written into a four-word queue. The result port gives one word per cycle while res_stall
// is low; command words are stalled while the packing stage holds an item and the queue has
// fewer than two free places, so a stream of codes that yields two bytes per symbol is held back
// by the result port, and otherwise runs at one symbol per cycle.
module huffman_bit_packer_unit
	import hbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = 16,
	parameter int SYMBOL_COUNT = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  in_word_t  cmd_data,
	output logic      res_valid,
	input  logic      res_stall,
	output out_word_t res_data
);

	localparam int CAP    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
	localparam int LEN_W  = $clog2(CAP + 1);
	localparam int CODE_W = CAP;
	localparam int IDX_W  = $clog2(SYMBOL_COUNT);

	logic                accept;
	logic                s1_adv;
	logic                room;
	logic                sym_ok;
	logic                valid_s1;
	logic [CMD_BITS-1:0] cmd_s1;
	logic                sym_ok_s1;
	logic [CODE_W-1:0]   rd_code;
	logic [LEN_W-1:0]    rd_len;
	pack_ctl_t           ctl;
	pack_res_t           res;
	pack_res_t           push;

	assign sym_ok    = ({1'b0, cmd_data.symbol} < (SYM_BITS + 1)'(SYMBOL_COUNT));
	assign s1_adv    = !valid_s1 || room;
	assign cmd_stall = !s1_adv;
	assign accept    = cmd_valid && s1_adv;

	hbp_code_table #(
		.SYMBOL_COUNT(SYMBOL_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_table (
		.clk        (clk),
		.wr_en      (accept && cmd_data.command == CMD_LOAD && sym_ok),
		.rd_en      (accept && cmd_data.command == CMD_ENCODE),
		.idx        (cmd_data.symbol[IDX_W-1:0]),
		.code_word  (cmd_data.code_word),
		.code_length(cmd_data.code_length),
		.rd_code_q  (rd_code),
		.rd_len_q   (rd_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_adv) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_data.command;
			sym_ok_s1 <= sym_ok;
		end
	end

	assign ctl = '{valid: valid_s1, cmd: cmd_s1, sym_ok: sym_ok_s1};

	hbp_packer u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.adv   (s1_adv),
		.code  (WORD_BITS'(rd_code)),
		.len   (LEN_BITS'(rd_len)),
		.res   (res)
	);

	always_comb begin
		push = res;
		if (!s1_adv) begin
			push.n = 2'd0;
		end
	end

	hbp_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res_data (res_data),
		.room     (room)
	);

endmodule

// ----- hdl/hbp_port_checker.sv -----
// Port checker for the Huffman bit packer result channel, bound to the top level.
`include "huffman_bit_packer_unit_macros.svh"

module hbp_port_checker
	import hbp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      res_valid,
	input logic      res_stall,
	input out_word_t res_data
);

	`HBP_ASSERT_NEXT(a_valid_held, res_valid && res_stall, res_valid)
	`HBP_ASSERT_NEXT(a_word_held, res_valid && res_stall, $stable(res_data))
	// Only a flush word carries padding, and it always ends its item.
	`HBP_ASSERT_SAME(a_pad_is_last, res_valid && res_data.pad_bits != 4'd0, res_data.is_last)
	`HBP_ASSERT_SAME(a_pad_range, res_valid, res_data.pad_bits <= 4'd8)
	// A flush with nothing pending gives an all-zero byte.
	`HBP_ASSERT_SAME(a_empty_flush, res_valid && res_data.pad_bits == 4'd8,
		res_data.out_byte == 8'd0)

endmodule

bind huffman_bit_packer_unit hbp_port_checker u_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the Huffman bit packer: random code tables, symbol runs, flushes.
`timescale 1ns / 1ps

module tb_top;
	import hbp_pkg::*;

	localparam int MAX_LEN        = 16;
	localparam int SYMBOLS        = 256;
	localparam int CODE_CAP       = (MAX_LEN < WORD_BITS) ? MAX_LEN : WORD_BITS;
	localparam int RANDOM_ITEMS   = 1800;
	localparam int LONG_HOLD      = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	// Tracks the code table and the pending bits, and holds the bytes the block still owes.
	class bitstream_tracker;
		logic [LEN_BITS+WORD_BITS-1:0] code_table [SYMBOLS];
		logic [PEND_BITS-1:0] held_bits;
		logic [PCNT_BITS-1:0] held_count;
		out_word_t owed_bytes [$];
		int errors, loads, encodes, flushes, ignored, words_checked;

		function new();
			foreach (code_table[i])
				code_table[i] = '0;
			held_bits = '0;
			held_count = '0;
			errors = 0;
			loads = 0;
			encodes = 0;
			flushes = 0;
			ignored = 0;
			words_checked = 0;
		endfunction

		function void note_command(in_word_t w);
			int unsigned len, cnt, pad, n;
			logic [31:0] acc, code;
			out_word_t produced [2];
			case (w.command)
				CMD_LOAD: begin
					loads++;
					if (w.symbol < SYMBOLS) begin
						len = (w.code_length > CODE_CAP) ? CODE_CAP : w.code_length;
						code = 32'(w.code_word) & ((32'd1 << len) - 32'd1);
						code_table[w.symbol] = {LEN_BITS'(len), WORD_BITS'(code)};
					end
				end
				CMD_ENCODE: begin
					encodes++;
					if (w.symbol < SYMBOLS) begin
						len = code_table[w.symbol][LEN_BITS+WORD_BITS-1:WORD_BITS];
						if (len > CODE_CAP)
							len = CODE_CAP;
						if (len != 0) begin
							acc = (32'(held_bits) << len) |
								32'(code_table[w.symbol][WORD_BITS-1:0]);
							cnt = held_count + len;
							n = 0;
							while (cnt >= BYTE_BITS && n < 2) begin
								cnt -= BYTE_BITS;
								produced[n].out_byte = BYTE_BITS'(acc >> cnt);
								produced[n].pad_bits = '0;
								produced[n].is_last = 1'b0;
								n++;
							end
							held_bits = PEND_BITS'(acc & ((32'd1 << cnt) - 32'd1));
							held_count = PCNT_BITS'(cnt);
							if (n > 0)
								produced[n-1].is_last = 1'b1;
							for (int i = 0; i < n; i++)
								owed_bytes.push_back(produced[i]);
						end
					end
				end
				CMD_FLUSH: begin
					flushes++;
					pad = BYTE_BITS - held_count;
					produced[0].out_byte = (pad >= BYTE_BITS) ? '0 :
						BYTE_BITS'(32'(held_bits) << pad);
					produced[0].pad_bits = PAD_BITS'(pad);
					produced[0].is_last = 1'b1;
					owed_bytes.push_back(produced[0]);
					held_bits = '0;
					held_count = '0;
				end
				default: begin
					ignored++;
				end
			endcase
		endfunction

		function void check_word(out_word_t got);
			out_word_t want;
			if (owed_bytes.size() == 0) begin
				errors++;
				$display("%0t: result word %h arrived with nothing expected", $time, got);
				return;
			end
			want = owed_bytes.pop_front();
			words_checked++;
			if (got.out_byte !== want.out_byte) begin
				errors++;
				$display("%0t: out_byte expected %h, got %h", $time, want.out_byte, got.out_byte);
			end
			if (got.pad_bits !== want.pad_bits) begin
				errors++;
				$display("%0t: pad_bits expected %0d, got %0d", $time, want.pad_bits, got.pad_bits);
			end
			if (got.is_last !== want.is_last) begin
				errors++;
				$display("%0t: is_last expected %b, got %b", $time, want.is_last, got.is_last);
			end
		endfunction

		function int pending_words();
			return owed_bytes.size();
		endfunction

		function void report_leftovers();
			if (owed_bytes.size() != 0) begin
				errors++;
				$display("%0t: %0d expected words never arrived", $time, owed_bytes.size());
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	in_word_t  cmd_data = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	out_word_t res_data;

	bitstream_tracker sb = new();

	bit         sym_loaded [SYMBOLS];
	logic [7:0] loaded_syms [$];
	bit         burst_mode = 1'b0;
	bit         hold_req = 1'b0;
	int         holds_done = 0;
	int         sent_items = 0;

	huffman_bit_packer_unit #(
		.MAX_CODE_LEN(MAX_LEN),
		.SYMBOL_COUNT(SYMBOLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_data(cmd_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			sb.note_command(cmd_data);
		if (arst_n && res_valid && !res_stall)
			sb.check_word(res_data);
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t make_word(logic [CMD_BITS-1:0] cmd, logic [SYM_BITS-1:0] sym,
		logic [WORD_BITS-1:0] code, logic [LEN_BITS-1:0] len);
		in_word_t w;
		w.command = cmd;
		w.symbol = sym;
		w.code_word = code;
		w.code_length = len;
		return w;
	endfunction

	// Called just after a rising edge; returns just after the edge that took the word.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = burst_mode ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		if (w.command != CMD_UNUSED)
			sent_items++;
	endtask

	task automatic load_code(input logic [SYM_BITS-1:0] sym, input logic [WORD_BITS-1:0] code,
		input logic [LEN_BITS-1:0] len);
		send_word(make_word(CMD_LOAD, sym, code, len));
		if (!sym_loaded[sym]) begin
			sym_loaded[sym] = 1'b1;
			loaded_syms.push_back(sym);
		end
	endtask

	task automatic load_random();
		int r;
		logic [LEN_BITS-1:0] len;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = LEN_BITS'($urandom_range(1, 8));
		else if (r < 88)
			len = LEN_BITS'($urandom_range(9, 16));
		else if (r < 94)
			len = '0;
		else
			len = LEN_BITS'($urandom_range(17, 31));
		load_code(SYM_BITS'($urandom_range(0, 255)), WORD_BITS'($urandom), len);
	endtask

	task automatic encode_symbol(input logic [SYM_BITS-1:0] sym);
		send_word(make_word(CMD_ENCODE, sym, WORD_BITS'($urandom), LEN_BITS'($urandom)));
	endtask

	task automatic flush_stream();
		send_word(make_word(CMD_FLUSH, SYM_BITS'($urandom), WORD_BITS'($urandom),
			LEN_BITS'($urandom)));
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_words() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int r, span;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				holds_done++;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 45) begin
					res_stall <= 1'b0;
					span = $urandom_range(1, 4);
				end else if (r < 80) begin
					res_stall <= 1'b1;
					span = $urandom_range(1, 3);
				end else if (r < 95) begin
					res_stall <= 1'b0;
					span = $urandom_range(10, 40);
				end else begin
					res_stall <= 1'b1;
					span = $urandom_range(15, 60);
				end
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	initial begin : stimulus
		int k, run, r, n_loads, msg;
		msg = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty flush, length extremes, clamping, a zero-length code,
		// the unused command, and encodes that give zero, one and two bytes.
		flush_stream();
		load_code(8'd0, 16'hFFFF, 5'd16);
		load_code(8'd255, 16'h0001, 5'd1);
		load_code(8'd1, 16'hA5C3, 5'd31);
		load_code(8'd2, 16'hFFFF, 5'd3);
		load_code(8'd3, 16'h1234, 5'd0);
		load_code(8'd4, 16'h0F0F, 5'd17);
		send_word(make_word(CMD_UNUSED, 8'hFF, 16'hFFFF, 5'd31));
		encode_symbol(8'd3);
		encode_symbol(8'd255);
		flush_stream();
		encode_symbol(8'd0);
		encode_symbol(8'd2);
		encode_symbol(8'd0);
		encode_symbol(8'd1);
		repeat (5) encode_symbol(8'd255);
		flush_stream();
		encode_symbol(8'd2);
		encode_symbol(8'd2);
		flush_stream();
		encode_symbol(8'd4);
		flush_stream();
		wait_drained();

		// Random part: each message may refresh part of the table, then encodes a run of
		// loaded symbols with some noise mixed in, and usually ends with a flush.
		sent_items = 0;
		while (sent_items < RANDOM_ITEMS) begin
			msg++;
			burst_mode = ($urandom_range(0, 3) == 0);
			if (msg % 25 == 20) begin
				hold_req = 1'b1;
				burst_mode = 1'b1;
			end
			n_loads = (loaded_syms.size() < 12) ? 12 : $urandom_range(0, 4);
			repeat (n_loads) load_random();
			run = $urandom_range(4, 40);
			for (k = 0; k < run; k++) begin
				r = $urandom_range(0, 99);
				if (r < 88)
					encode_symbol(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
				else if (r < 92)
					send_word(make_word(CMD_UNUSED, SYM_BITS'($urandom),
						WORD_BITS'($urandom), LEN_BITS'($urandom)));
				else if (r < 96)
					load_random();
				else
					flush_stream();
			end
			if ($urandom_range(0, 7) != 0)
				flush_stream();
			if (msg % 12 == 0)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		sb.report_leftovers();
		$display("Covered %0d loads, %0d encodes, %0d flushes and %0d ignored commands.",
			sb.loads, sb.encodes, sb.flushes, sb.ignored);
		$display("Checked %0d output words; the output side was held off at length %0d times.",
			sb.words_checked, holds_done);
		if (sb.errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/hbp_pkg.sv
hdl/hbp_code_table.sv
hdl/hbp_packer.sv
hdl/hbp_out_fifo.sv
hdl/huffman_bit_packer_unit.sv
hdl/hbp_port_checker.sv
tb/sv/tb_top.sv
